// ===== rtl/gradient_non_max_suppression_macros.svh =====
// ----------------------------------------------------------------------------
// gradient_non_max_suppression_macros
// Assertion macros shared by the non-max suppression RTL.
// ----------------------------------------------------------------------------
`ifndef GRADIENT_NON_MAX_SUPPRESSION_MACROS_SVH
`define GRADIENT_NON_MAX_SUPPRESSION_MACROS_SVH

`ifndef SYNTHESIS

// checked only out of reset
`define GNMS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define GNMS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GNMS_ASSERT(label, clk, rst, prop, msg)
`define GNMS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

// ===== rtl/gnms_pkg.sv =====
// ----------------------------------------------------------------------------
// gnms_pkg
// Types, sizes and angle constants for gradient non-max suppression.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gnms_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int MAG_BITS    = 16;
  localparam int ANGLE_BITS  = 15;
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 12;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int ROW_BITS    = 12;
  localparam int CFG_BITS    = 12;

  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  // radians * 4096, one bit wider than the angle so the fold cannot overflow
  localparam logic signed [ANGLE_BITS:0] PI_Q12     = 16'sd12868;
  localparam logic signed [ANGLE_BITS:0] TWO_PI_Q12 = 16'sd25736;
  localparam logic signed [ANGLE_BITS:0] SECT_A     = 16'sd1609;
  localparam logic signed [ANGLE_BITS:0] SECT_B     = 16'sd4826;
  localparam logic signed [ANGLE_BITS:0] SECT_C     = 16'sd8043;
  localparam logic signed [ANGLE_BITS:0] SECT_D     = 16'sd11260;

  typedef logic [MAG_BITS-1:0] mag_t;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } reg_index_t;

  // neighbor pair along the gradient
  typedef enum logic [1:0] {
    SECT_HORZ      = 2'd0,  // left / right
    SECT_DIAG_UP   = 2'd1,  // upper right / lower left
    SECT_VERT      = 2'd2,  // up / down
    SECT_DIAG_DOWN = 2'd3   // upper left / lower right
  } sector_t;

  typedef struct packed {
    mag_t                up;
    mag_t                mid;
    mag_t                mag;
    sector_t             sect;   // sector of the next window centre
    logic                emit;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } q_item_t;

  typedef struct packed {
    logic [QCNT_BITS-1:0] count;
    logic                 empty;
  } q_status_t;

  function automatic sector_t classify(input logic signed [ANGLE_BITS-1:0] ang);
    logic signed [ANGLE_BITS:0] a;
    logic signed [ANGLE_BITS:0] f;
    sector_t                    s;
    a = {ang[ANGLE_BITS-1], ang};
    if (a < -PI_Q12) begin
      f = a + TWO_PI_Q12;
    end else if (a < 0) begin
      f = a + PI_Q12;
    end else if (a >= PI_Q12) begin
      f = a - PI_Q12;
    end else begin
      f = a;
    end
    if (f < SECT_A || f >= SECT_D) begin
      s = SECT_HORZ;
    end else if (f < SECT_B) begin
      s = SECT_DIAG_UP;
    end else if (f < SECT_C) begin
      s = SECT_VERT;
    end else begin
      s = SECT_DIAG_DOWN;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gnms_front.sv =====
// ----------------------------------------------------------------------------
// gnms_front
// Pixel intake: raster counters, sector classification, line store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gradient_non_max_suppression_macros.svh"

module gnms_front
  import gnms_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [CFG_BITS-1:0]           cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [MAG_BITS-1:0]           magnitude,
  input  wire logic signed [ANGLE_BITS-1:0]  angle,
  input  wire q_status_t                     q_status,
  output logic                               push,
  output q_item_t                            push_item
);

  typedef struct packed {
    mag_t    mid;
    sector_t sect;
    mag_t    up;
  } line_word_t;

  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;
  logic [COL_BITS-1:0]    col_count;
  logic [ROW_BITS-1:0]    row_count;

  line_word_t line_mem [MAX_WIDTH];
  line_word_t rd_word;

  logic                b_valid;
  mag_t                b_mag;
  sector_t             b_sect;
  logic [COL_BITS-1:0] b_addr;
  logic                b_emit;
  logic [ROW_BITS-1:0] b_row;
  logic [COL_BITS-1:0] b_col;
  logic                b_last;

  logic                   in_accept;
  logic [QCNT_BITS-1:0]   level;
  logic [WIDTH_BITS-1:0]  w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [WIDTH_BITS-1:0]  col_inc;
  logic [ROW_BITS:0]      row_inc;
  logic                   col_wrap;
  logic                   row_wrap;

  // count in-flight beat as already queued so the write-back stage never stalls
  assign level     = q_status.count + QCNT_BITS'(b_valid);
  assign in_stall  = level >= QCNT_BITS'(QDEPTH);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (image_width < WIDTH_BITS'(3)) begin
      w_eff = WIDTH_BITS'(3);
    end else if (image_width > WIDTH_BITS'(MAX_WIDTH)) begin
      w_eff = WIDTH_BITS'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff    = (image_height < HEIGHT_BITS'(3)) ? HEIGHT_BITS'(3) : image_height;
    col_inc  = {1'b0, col_count} + WIDTH_BITS'(1);
    row_inc  = {1'b0, row_count} + (ROW_BITS + 1)'(1);
    col_wrap = col_inc >= w_eff;
    row_wrap = row_inc >= {1'b0, h_eff};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_BITS'(1024);
      image_height <= HEIGHT_BITS'(480);
      col_count    <= '0;
      row_count    <= '0;
      b_valid      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_BITS-1:0];
          REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_BITS-1:0];
          default: ;
        endcase
      end
      b_valid <= in_accept;
      if (in_accept) begin
        if (col_wrap) begin
          col_count <= '0;
          row_count <= row_wrap ? '0 : row_inc[ROW_BITS-1:0];
        end else begin
          col_count <= col_inc[COL_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      b_mag  <= magnitude;
      b_sect <= classify(angle);
      b_addr <= col_count;
      b_emit <= (row_count >= ROW_BITS'(2)) && (col_count >= COL_BITS'(2));
      b_row  <= row_count - ROW_BITS'(1);
      b_col  <= col_count - COL_BITS'(1);
      b_last <= row_wrap && col_wrap;
    end
  end

  // line store: read on accept, write back in the next cycle (middle row moves up)
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_word <= line_mem[col_count];
    end
    if (b_valid) begin
      line_mem[b_addr] <= '{mid: b_mag, sect: b_sect, up: rd_word.mid};
    end
  end

  assign push = b_valid;
  always_comb begin
    push_item.up   = rd_word.up;
    push_item.mid  = rd_word.mid;
    push_item.mag  = b_mag;
    push_item.sect = rd_word.sect;
    push_item.emit = b_emit;
    push_item.row  = b_row;
    push_item.col  = b_col;
    push_item.last = b_last;
  end

  `GNMS_ASSERT(a_no_rw_clash, clk, rst, (in_accept && b_valid) |-> (col_count != b_addr), "line store read hits pending write")

endmodule

`default_nettype wire

// ===== rtl/gnms_queue.sv =====
// ----------------------------------------------------------------------------
// gnms_queue
// Short FIFO between pixel intake and suppression.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gradient_non_max_suppression_macros.svh"

module gnms_queue
  import gnms_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  input  wire q_item_t push_item,
  input  wire logic    pop,
  output q_item_t      head,
  output q_status_t    status
);

  q_item_t              entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_BITS'(1);
        2'b01:   count <= count - QCNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  assign head         = entries[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);

  `GNMS_ASSERT(a_no_overflow, clk, rst, push |-> (count < QCNT_BITS'(QDEPTH)), "queue overflow")
  `GNMS_ASSERT(a_no_underflow, clk, rst, pop |-> (count != '0), "queue underflow")
  `GNMS_ASSERT(a_count_up, clk, rst, (push && !pop) |=> (count == $past(count) + QCNT_BITS'(1)), "queue count lost a push")

endmodule

`default_nettype wire

// ===== rtl/gnms_back.sv =====
// ----------------------------------------------------------------------------
// gnms_back
// 3x3 magnitude window, suppression compare and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gnms_back
  import gnms_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire q_item_t        head,
  input  wire q_status_t      q_status,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [MAG_BITS-1:0] value,
  output logic [ROW_BITS-1:0] row,
  output logic [COL_BITS-1:0] col,
  output logic                last
);

  mag_t    win      [3][3];
  mag_t    win_next [3][3];
  sector_t centre_sect;
  mag_t    n1;
  mag_t    n2;
  mag_t    centre;
  mag_t    result;
  logic    load;

  // beats that emit nothing only move the window and never wait on the output
  assign pop  = !q_status.empty && (!head.emit || !out_valid || !out_stall);
  assign load = pop && head.emit;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_next[k][0] = win[k][1];
      win_next[k][1] = win[k][2];
    end
    win_next[0][2] = head.up;
    win_next[1][2] = head.mid;
    win_next[2][2] = head.mag;
    centre = win_next[1][1];
    case (centre_sect)
      SECT_HORZ: begin
        n1 = win_next[1][0];
        n2 = win_next[1][2];
      end
      SECT_DIAG_UP: begin
        n1 = win_next[0][2];
        n2 = win_next[2][0];
      end
      SECT_VERT: begin
        n1 = win_next[0][1];
        n2 = win_next[2][1];
      end
      SECT_DIAG_DOWN: begin
        n1 = win_next[0][0];
        n2 = win_next[2][2];
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
    result = (centre >= n1 && centre >= n2) ? centre : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid   <= 1'b0;
      centre_sect <= SECT_HORZ;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        centre_sect <= head.sect;
        win         <= win_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      value <= result;
      row   <= head.row;
      col   <= head.col;
      last  <= head.last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gradient_non_max_suppression.sv =====
// ----------------------------------------------------------------------------
// gradient_non_max_suppression
// Canny non-max suppression over a streamed gradient image.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   magnitude, angle
//   out      output     out_valid / out_stall value, row, col, last
//   cfg      input      cfg_write             cfg_index, cfg_data
//
// One pixel per clock sustained while out_stall is low; the line store's
// single read and single write port each serve one pixel a cycle. Beats pass
// intake registers, queue and output register. Reset clears counters,
// window and queue at once; the line store has no clearing pass. An output
// stall backs up through a four-entry queue before in_stall rises.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gradient_non_max_suppression
  import gnms_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_write,
  input  wire logic                          cfg_index,
  input  wire logic [CFG_BITS-1:0]           cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [MAG_BITS-1:0]           magnitude,
  input  wire logic signed [ANGLE_BITS-1:0]  angle,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [MAG_BITS-1:0]                value,
  output logic [ROW_BITS-1:0]                row,
  output logic [COL_BITS-1:0]                col,
  output logic                               last
);

  q_status_t q_status;
  logic      push;
  q_item_t   push_item;
  logic      pop;
  q_item_t   head;

  gnms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .magnitude (magnitude),
    .angle     (angle),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  gnms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  gnms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .row       (row),
    .col       (col),
    .last      (last)
  );

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming Canny non-max suppression block.
// Pixel beats go in with random gaps and output stalls. A predictor with its
// own line stores and 3x3 window computes each interior result in order, and
// every result beat is compared field by field. The run walks a set of image
// sizes: degenerate ones that saturate, the widest row setting, tall frames
// and size changes in mid-frame.
// ----------------------------------------------------------------------------

module testbench;
  import gnms_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 10;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int NUM_PHASES      = 12;

  typedef logic signed [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    mag_t                value;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } nms_pixel_t;

  typedef struct packed {
    mag_t       mag;
    angle_t     ang;
    logic       typed;
    nms_pixel_t want;
  } dir_pixel_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] w_data;
    logic [CFG_BITS-1:0] h_data;
    logic [15:0]         beats;
    logic [7:0]          tx_pct;
    logic [7:0]          rx_pct;
    logic                hold;
    logic                pause;
  } phase_t;

  // Two 3-wide, 4-tall frames. Across both frames the centers (1,1) and (2,1) cover
  // all four sectors, the angle fold on both sides and ties with a neighbor.
  localparam dir_pixel_t DIRECTED [24] = '{
    '{16'd0,     15'sd12868,  1'b0, '0},
    '{16'd0,     15'sd0,      1'b0, '0},
    '{16'd0,     15'sd0,      1'b0, '0},
    '{16'd2,     15'sd0,      1'b0, '0},
    '{16'd65535, 15'sd16383,  1'b0, '0},
    '{16'd0,     15'sd0,      1'b0, '0},
    '{16'd0,     15'sd0,      1'b0, '0},
    '{16'd1,     15'h4000,    1'b0, '0},
    '{16'd0,     15'sd0,      1'b1, '{16'd65535, 12'd1, 10'd1, 1'b0}},
    '{16'd0,     15'sd0,      1'b0, '0},
    '{16'd0,     15'sd0,      1'b0, '0},
    '{16'd0,     15'sd0,      1'b1, '{16'd0,     12'd2, 10'd1, 1'b1}},
    '{16'd7,     15'sd0,      1'b0, '0},
    '{16'd7,     15'sd0,      1'b0, '0},
    '{16'd7,     15'sd0,      1'b0, '0},
    '{16'd500,   15'sd0,      1'b0, '0},
    '{16'd500,   -15'sd12868, 1'b0, '0},
    '{16'd499,   15'sd0,      1'b0, '0},
    '{16'd9,     15'sd0,      1'b0, '0},
    '{16'd65535, 15'sd6000,   1'b0, '0},
    '{16'd9,     15'sd0,      1'b1, '{16'd500,   12'd1, 10'd1, 1'b0}},
    '{16'd1,     15'sd0,      1'b0, '0},
    '{16'd65535, 15'sd0,      1'b0, '0},
    '{16'd1,     15'sd0,      1'b1, '{16'd65535, 12'd2, 10'd1, 1'b1}}
  };

  // width data, height data, beats, tx idle %, rx idle %, hold-off, pause
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{12'd5,    12'd4,    16'd90,   8'd20, 8'd20, 1'b0, 1'b0},
    '{12'd0,    12'd0,    16'd70,   8'd0,  8'd30, 1'b0, 1'b0},
    '{12'h803,  12'd2,    16'd40,   8'd30, 8'd0,  1'b0, 1'b0},
    '{12'd7,    12'd6,    16'd130,  8'd0,  8'd0,  1'b1, 1'b0},
    '{12'd1,    12'd1,    16'd50,   8'd40, 8'd40, 1'b0, 1'b0},
    '{12'd16,   12'd5,    16'd120,  8'd15, 8'd15, 1'b0, 1'b1},
    '{12'd2047, 12'd3,    16'd30,   8'd10, 8'd10, 1'b0, 1'b0},
    '{12'd1025, 12'd4095, 16'd60,   8'd20, 8'd20, 1'b0, 1'b0},
    '{12'd6,    12'd4095, 16'd150,  8'd20, 8'd20, 1'b0, 1'b0},
    '{12'd9,    12'd7,    16'd120,  8'd25, 8'd25, 1'b0, 1'b0},
    '{12'd4,    12'd3,    16'd100,  8'd0,  8'd30, 1'b1, 1'b0},
    '{12'd10,   12'd4,    16'd160,  8'd0,  8'd0,  1'b0, 1'b0}
  };

  logic                clk;
  logic                rst       = 1'b1;
  logic                cfg_write = 1'b0;
  logic                cfg_index = REG_IMAGE_WIDTH;
  logic [CFG_BITS-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  mag_t                magnitude = '0;
  angle_t              angle     = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MAG_BITS-1:0] value;
  logic [ROW_BITS-1:0] row;
  logic [COL_BITS-1:0] col;
  logic                last;

  gradient_non_max_suppression u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .magnitude (magnitude),
    .angle     (angle),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .row       (row),
    .col       (col),
    .last      (last)
  );

  // predictor state
  mag_t                   upper_line  [MAX_WIDTH];
  mag_t                   middle_line [MAX_WIDTH];
  angle_t                 angle_line  [MAX_WIDTH];
  mag_t                   win         [9];
  angle_t                 ctr_angle;
  int unsigned            cur_row;
  int unsigned            cur_col;
  logic [WIDTH_BITS-1:0]  width_reg;
  logic [HEIGHT_BITS-1:0] height_reg;

  nms_pixel_t  nms_pixels_due [$];

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_off_req = 1'b0;
  int unsigned beats_in = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned eff_width(input int unsigned w);
    if (w < 3) return 3;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return w;
  endfunction

  // Advances the window by one pixel; returns 1 when an interior result is due.
  function automatic bit predict_nms_pixel(input mag_t mag, input angle_t ang,
                                           output nms_pixel_t res);
    int unsigned w, h, c, r, ci;
    int          f;
    mag_t        up, mid, n1, n2;
    angle_t      old_ang;
    sector_t     dir;
    bit          hit;
    w  = eff_width(int'(width_reg));
    h  = (height_reg < HEIGHT_BITS'(3)) ? 3 : int'(height_reg);
    c  = cur_col;
    r  = cur_row;
    ci = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
    up      = upper_line[ci];
    mid     = middle_line[ci];
    old_ang = angle_line[ci];
    for (int k = 0; k < 3; k++) begin
      win[k*3]   = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = mag;
    res = '0;
    hit = (r >= 2 && c >= 2);
    if (hit) begin
      f = int'(ctr_angle);
      while (f < 0) f += int'(PI_Q12);
      while (f >= int'(PI_Q12)) f -= int'(PI_Q12);
      if (f < SECT_A || f >= SECT_D) dir = SECT_HORZ;
      else if (f < SECT_B)           dir = SECT_DIAG_UP;
      else if (f < SECT_C)           dir = SECT_VERT;
      else                           dir = SECT_DIAG_DOWN;
      case (dir)
        SECT_HORZ:    begin n1 = win[3]; n2 = win[5]; end
        SECT_DIAG_UP: begin n1 = win[2]; n2 = win[6]; end
        SECT_VERT:    begin n1 = win[1]; n2 = win[7]; end
        default:      begin n1 = win[0]; n2 = win[8]; end
      endcase
      res.value = (win[4] >= n1 && win[4] >= n2) ? win[4] : '0;
      res.row   = ROW_BITS'(r - 1);
      res.col   = COL_BITS'(c - 1);
      res.last  = (r + 1 >= h && c + 1 >= w);
    end
    ctr_angle       = old_ang;
    upper_line[ci]  = mid;
    middle_line[ci] = mag;
    angle_line[ci]  = ang;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    cur_col = c % (1 << COL_BITS);
    cur_row = r % (1 << ROW_BITS);
    return hit;
  endfunction

  // One input beat; the prediction is made at the edge that accepts it.
  task automatic send_pixel(input mag_t mag, input angle_t ang, input logic typed,
                            input nms_pixel_t want);
    nms_pixel_t res;
    int         gap;
    if (tx_idle_pct != 0 && $urandom_range(99, 0) < tx_idle_pct) begin
      gap = $urandom_range(10, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    magnitude <= mag;
    angle     <= ang;
    @(posedge clk);
    while (in_stall) begin
      stall_cycles++;
      @(posedge clk);
    end
    beats_in++;
    if (predict_nms_pixel(mag, ang, res)) nms_pixels_due.push_back(typed ? want : res);
  endtask

  task automatic send_random_pixel();
    mag_t m;
    int   a;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: m = mag_t'($urandom_range(65535, 0));
      4, 5, 6:    m = mag_t'($urandom_range(7, 0));   // small values give frequent ties
      7:          m = 16'hFFFF - mag_t'($urandom_range(7, 0));
      default:    m = $urandom_range(1, 0) ? 16'hFFFF : 16'h0000;
    endcase
    case ($urandom_range(9, 0))
      0, 1, 2, 3, 4: a = int'($urandom_range(25736, 0)) - int'(PI_Q12);
      5, 6:          a = int'($urandom_range(32767, 0)) - 16384;
      7, 8: begin
        // straddle a sector bound, on either side of the fold
        case ($urandom_range(3, 0))
          0:       a = int'(SECT_A);
          1:       a = int'(SECT_B);
          2:       a = int'(SECT_C);
          default: a = int'(SECT_D);
        endcase
        a = a + int'($urandom_range(3, 0)) - 2;
        if ($urandom_range(1, 0) == 1) a = a - int'(PI_Q12);
      end
      default: begin
        case ($urandom_range(4, 0))
          0:       a = -16384;
          1:       a = 16383;
          2:       a = -int'(PI_Q12);
          3:       a = int'(PI_Q12);
          default: a = 0;
        endcase
      end
    endcase
    send_pixel(m, ANGLE_BITS'(a), 1'b0, '0);
  endtask

  // valid drops for at least one edge so the next beat is driven at a later step
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (nms_pixels_due.size() != 0) @(posedge clk);
  endtask

  // Size registers change only with the pipe empty and settled.
  task automatic reg_pair(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    width_reg = w[WIDTH_BITS-1:0];
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    height_reg = h[HEIGHT_BITS-1:0];
    cfg_write <= 1'b0;
  endtask

  // receiver pacing: random stall bursts, plus a long hold-off on request
  initial begin : rx_pace
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(99, 0) < rx_idle_pct) begin
        gap = $urandom_range(10, 1);
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    nms_pixel_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (nms_pixels_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result beat: value=%0d row=%0d col=%0d last=%0b",
                   value, row, col, last);
        mismatches++;
      end else begin
        want = nms_pixels_due.pop_front();
        if (value !== want.value || row !== want.row || col !== want.col ||
            last !== want.last) begin
          if (mismatches < 10)
            $display("mismatch: expected value=%0d row=%0d col=%0d last=%0b,",
                     want.value, want.row, want.col, want.last,
                     " got value=%0d row=%0d col=%0d last=%0b",
                     value, row, col, last);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout with %0d results outstanding", nms_pixels_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    phase_t ph;
    for (int k = 0; k < MAX_WIDTH; k++) begin
      upper_line[k]  = '0;
      middle_line[k] = '0;
      angle_line[k]  = '0;
    end
    for (int k = 0; k < 9; k++) win[k] = '0;
    ctr_angle  = '0;
    cur_row    = 0;
    cur_col    = 0;
    width_reg  = WIDTH_BITS'(1024);
    height_reg = HEIGHT_BITS'(480);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    reg_pair(CFG_BITS'(3), CFG_BITS'(4));
    foreach (DIRECTED[i])
      send_pixel(DIRECTED[i].mag, DIRECTED[i].ang, DIRECTED[i].typed, DIRECTED[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      ph = PHASES[p];
      // A wider row would read line entries never written; finish the
      // frame first (height forced to 3 so it ends soon).
      if (eff_width(int'(ph.w_data[WIDTH_BITS-1:0])) > eff_width(int'(width_reg)) &&
          (cur_row != 0 || cur_col != 0)) begin
        reg_pair(CFG_BITS'(width_reg), CFG_BITS'(3));
        while (cur_row != 0 || cur_col != 0) send_random_pixel();
      end
      reg_pair(ph.w_data, ph.h_data);
      tx_idle_pct = int'(ph.tx_pct);
      rx_idle_pct = int'(ph.rx_pct);
      if (ph.hold) hold_off_req = 1'b1;
      for (int i = 0; i < ph.beats; i++) begin
        if (ph.pause && i == ph.beats / 2) drain_results();
        send_random_pixel();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("covered %0d pixel beats and %0d result beats over %0d size settings",
             beats_in, results_seen, NUM_PHASES + 1);
    $display("input held off for %0d cycles; %0d mismatches, %0d results outstanding",
             stall_cycles, mismatches, nms_pixels_due.size());
    if (mismatches == 0 && nms_pixels_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
